FILE: hdl/chi_pkg.sv
package chi_pkg;

  localparam int T_W       = 17;
  localparam int SPAN_W    = 32;
  localparam int POS_W     = 40;
  localparam int VEL_W     = 32;
  localparam int ACC_W     = 54;
  localparam int MAG_W     = ACC_W - 1;
  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = 5;

  typedef struct packed {
    logic [T_W-1:0]          t;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] c_a;
    logic signed [ACC_W-1:0] c_b;
    logic signed [ACC_W-1:0] c_c;
  } chi_horner_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic                    sat;
  } chi_result_t;

endpackage

FILE: hdl/chi_if.sv
interface chi_in_if;
  logic                            valid;
  logic                            ready;
  logic [chi_pkg::T_W-1:0]         frac_t;
  logic [chi_pkg::SPAN_W-1:0]      step_span;
  logic signed [chi_pkg::POS_W-1:0] start_pos;
  logic signed [chi_pkg::VEL_W-1:0] start_vel;
  logic signed [chi_pkg::POS_W-1:0] end_pos;
  logic signed [chi_pkg::VEL_W-1:0] end_vel;

  modport source (
    output valid, frac_t, step_span, start_pos, start_vel, end_pos, end_vel,
    input  ready
  );
  modport sink (
    input  valid, frac_t, step_span, start_pos, start_vel, end_pos, end_vel,
    output ready
  );
endinterface

interface chi_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [chi_pkg::POS_W-1:0] interp_pos;
  logic                             saturated;

  modport source (output valid, interp_pos, saturated, input ready);
  modport sink (input valid, interp_pos, saturated, output ready);
endinterface

FILE: hdl/cubic_hermite_interpolator_core.sv
// Path from an input transaction to the result showing valid:
// (5 coefficient stages, 3 Horner steps of 4 stages, 1 saturation stage, buffer write).
// Throughput: one transaction per cycle while credits remain; the 32-entry result
// buffer and its credit count set how long input stays ready while output stalls.
// Reset (rst_n low, synchronous) clears pipeline valid bits, credits and buffer pointers.
module cubic_hermite_interpolator_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  chi_in_if.sink    in_chan,
  chi_out_if.source out_chan
);
  import chi_pkg::*;

  localparam int HORNER_STEPS = 3;
  localparam logic signed [ACC_W-1:0] POS_MAX_X =
    {{(ACC_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] POS_MIN_X =
    {{(ACC_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

  logic        in_fire;
  logic        credit_ok;
  logic        h_vld  [HORNER_STEPS+1];
  chi_horner_t h_item [HORNER_STEPS+1];
  chi_result_t res_r, res_nxt;
  logic        res_vld_r;
  logic signed [ACC_W-1:0] fin;

  assign in_fire       = in_chan.valid & in_chan.ready;
  assign in_chan.ready = credit_ok;

  chi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (in_fire),
    .frac_t    (in_chan.frac_t),
    .step_span (in_chan.step_span),
    .start_pos (in_chan.start_pos),
    .start_vel (in_chan.start_vel),
    .end_pos   (in_chan.end_pos),
    .end_vel   (in_chan.end_vel),
    .vld_o     (h_vld[0]),
    .item_o    (h_item[0])
  );

  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
    chi_horner_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (h_vld[g]),
      .item_i (h_item[g]),
      .vld_o  (h_vld[g+1]),
      .item_o (h_item[g+1])
    );
  end

  always_comb begin
    fin = h_item[HORNER_STEPS].acc;
    if (fin > POS_MAX_X) begin
      res_nxt.pos = POS_MAX_X[POS_W-1:0];
      res_nxt.sat = 1'b1;
    end else if (fin < POS_MIN_X) begin
      res_nxt.pos = POS_MIN_X[POS_W-1:0];
      res_nxt.sat = 1'b1;
    end else begin
      res_nxt.pos = fin[POS_W-1:0];
      res_nxt.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= h_vld[HORNER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  chi_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .credit_ok (credit_ok),
    .wr_vld    (res_vld_r),
    .wr_data   (res_r),
    .out_chan  (out_chan)
  );

endmodule

FILE: hdl/chi_front.sv
module chi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  logic [chi_pkg::T_W-1:0]          frac_t,
  input  logic [chi_pkg::SPAN_W-1:0]       step_span,
  input  logic signed [chi_pkg::POS_W-1:0] start_pos,
  input  logic signed [chi_pkg::VEL_W-1:0] start_vel,
  input  logic signed [chi_pkg::POS_W-1:0] end_pos,
  input  logic signed [chi_pkg::VEL_W-1:0] end_vel,
  output logic                             vld_o,
  output chi_pkg::chi_horner_t             item_o
);
  import chi_pkg::*;

  localparam int CMP_W  = (FRAC_BITS + 1 > T_W) ? FRAC_BITS + 1 : T_W;
  localparam logic [CMP_W-1:0] ONE_T = CMP_W'(1) << FRAC_BITS;
  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = VEL_W + SPAN_W;
  localparam int VT_SH  = 16;
  localparam int Q_W    = PROD_W - VT_SH;
  localparam int VD_W   = Q_W + 1;
  localparam logic [PROD_W-1:0] VT_HALF = PROD_W'(1) << (VT_SH - 1);

  typedef struct packed {
    logic [T_W-1:0]           t;
    logic [SPAN_W-1:0]        span;
    logic [VEL_W-1:0]         v0m;
    logic [VEL_W-1:0]         v1m;
    logic                     neg0;
    logic                     neg1;
    logic signed [DIFF_W-1:0] d;
    logic signed [POS_W-1:0]  p0;
  } s1_t;

  typedef struct packed {
    logic [T_W-1:0]           t;
    logic [PROD_W-1:0]        pv0;
    logic [PROD_W-1:0]        pv1;
    logic                     neg0;
    logic                     neg1;
    logic signed [DIFF_W-1:0] d;
    logic signed [POS_W-1:0]  p0;
  } s2_t;

  typedef struct packed {
    logic [T_W-1:0]           t;
    logic [Q_W-1:0]           q0;
    logic [Q_W-1:0]           q1;
    logic                     neg0;
    logic                     neg1;
    logic signed [DIFF_W-1:0] d;
    logic signed [POS_W-1:0]  p0;
  } s3_t;

  typedef struct packed {
    logic [T_W-1:0]           t;
    logic signed [VD_W-1:0]   vd0;
    logic signed [VD_W-1:0]   vd1;
    logic signed [DIFF_W-1:0] d;
    logic signed [POS_W-1:0]  p0;
  } s4_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  chi_horner_t out_r, out_nxt;
  logic [4:0] vld_r, vld_nxt;

  logic [CMP_W-1:0]        t_ext;
  logic [PROD_W-1:0]       rnd0, rnd1;
  logic signed [ACC_W-1:0] dx, v0x, v1x;

  always_comb begin
    t_ext       = CMP_W'(frac_t);
    s1_nxt.t    = (t_ext > ONE_T) ? ONE_T[T_W-1:0] : frac_t;
    s1_nxt.span = step_span;
    s1_nxt.neg0 = start_vel[VEL_W-1];
    s1_nxt.neg1 = end_vel[VEL_W-1];
    s1_nxt.v0m  = start_vel[VEL_W-1] ? VEL_W'(~start_vel + 1'b1) : VEL_W'(start_vel);
    s1_nxt.v1m  = end_vel[VEL_W-1] ? VEL_W'(~end_vel + 1'b1) : VEL_W'(end_vel);
    s1_nxt.d    = DIFF_W'(end_pos) - DIFF_W'(start_pos);
    s1_nxt.p0   = start_pos;
  end

  always_comb begin
    s2_nxt.t    = s1_r.t;
    s2_nxt.pv0  = s1_r.v0m * s1_r.span;
    s2_nxt.pv1  = s1_r.v1m * s1_r.span;
    s2_nxt.neg0 = s1_r.neg0;
    s2_nxt.neg1 = s1_r.neg1;
    s2_nxt.d    = s1_r.d;
    s2_nxt.p0   = s1_r.p0;
  end

  // round to nearest, ties away from zero, on the magnitude
  always_comb begin
    rnd0        = s2_r.pv0 + VT_HALF;
    rnd1        = s2_r.pv1 + VT_HALF;
    s3_nxt.t    = s2_r.t;
    s3_nxt.q0   = rnd0[PROD_W-1:VT_SH];
    s3_nxt.q1   = rnd1[PROD_W-1:VT_SH];
    s3_nxt.neg0 = s2_r.neg0;
    s3_nxt.neg1 = s2_r.neg1;
    s3_nxt.d    = s2_r.d;
    s3_nxt.p0   = s2_r.p0;
  end

  always_comb begin
    s4_nxt.t   = s3_r.t;
    s4_nxt.vd0 = s3_r.neg0 ? (VD_W'(0) - VD_W'(s3_r.q0)) : VD_W'(s3_r.q0);
    s4_nxt.vd1 = s3_r.neg1 ? (VD_W'(0) - VD_W'(s3_r.q1)) : VD_W'(s3_r.q1);
    s4_nxt.d   = s3_r.d;
    s4_nxt.p0  = s3_r.p0;
  end

  always_comb begin
    dx          = ACC_W'(s4_r.d);
    v0x         = ACC_W'(s4_r.vd0);
    v1x         = ACC_W'(s4_r.vd1);
    out_nxt.t   = s4_r.t;
    out_nxt.acc = v0x + v1x - (dx <<< 1);
    out_nxt.c_a = (dx <<< 1) + dx - (v0x <<< 1) - v1x;
    out_nxt.c_b = v0x;
    out_nxt.c_c = ACC_W'(s4_r.p0);
  end

  assign vld_nxt = {vld_r[3:0], vld_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    s4_r  <= s4_nxt;
    out_r <= out_nxt;
  end

  assign vld_o  = vld_r[4];
  assign item_o = out_r;

endmodule

FILE: hdl/chi_horner_step.sv
module chi_horner_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  chi_pkg::chi_horner_t item_i,
  output logic                 vld_o,
  output chi_pkg::chi_horner_t item_o
);
  import chi_pkg::*;

  localparam int LO_W   = 32;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int WIDE_W = MAG_W + T_W;
  localparam logic [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    chi_horner_t      it;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } m1_t;

  typedef struct packed {
    chi_horner_t           it;
    logic                  neg;
    logic [LO_W+T_W-1:0]   lo_p;
    logic [HI_W+T_W-1:0]   hi_p;
  } m2_t;

  typedef struct packed {
    chi_horner_t      it;
    logic             neg;
    logic [MAG_W-1:0] r;
  } m3_t;

  m1_t m1_r, m1_nxt;
  m2_t m2_r, m2_nxt;
  m3_t m3_r, m3_nxt;
  chi_horner_t out_r, out_nxt;
  logic [3:0]  vld_r, vld_nxt;

  logic [ACC_W-1:0]  neg_acc;
  logic [WIDE_W-1:0] r_sum;
  logic [ACC_W-1:0]  r_x;

  always_comb begin
    neg_acc    = ACC_W'(0) - item_i.acc;
    m1_nxt.it  = item_i;
    m1_nxt.neg = item_i.acc[ACC_W-1];
    m1_nxt.mag = item_i.acc[ACC_W-1] ? neg_acc[MAG_W-1:0] : item_i.acc[MAG_W-1:0];
  end

  always_comb begin
    m2_nxt.it   = m1_r.it;
    m2_nxt.neg  = m1_r.neg;
    m2_nxt.lo_p = m1_r.mag[LO_W-1:0] * m1_r.it.t;
    m2_nxt.hi_p = m1_r.mag[MAG_W-1:LO_W] * m1_r.it.t;
  end

  // high partial is a multiple of 2^FRAC_BITS, so only the low one rounds
  always_comb begin
    r_sum = (WIDE_W'(m2_r.hi_p) << (LO_W - FRAC_BITS))
          + ((WIDE_W'(m2_r.lo_p) + HALF) >> FRAC_BITS);
    m3_nxt.it  = m2_r.it;
    m3_nxt.neg = m2_r.neg;
    m3_nxt.r   = r_sum[MAG_W-1:0];
  end

  always_comb begin
    r_x         = ACC_W'(m3_r.r);
    out_nxt.t   = m3_r.it.t;
    out_nxt.acc = m3_r.neg ? (m3_r.it.c_a - r_x) : (m3_r.it.c_a + r_x);
    out_nxt.c_a = m3_r.it.c_b;
    out_nxt.c_b = m3_r.it.c_c;
    out_nxt.c_c = '0;
  end

  assign vld_nxt = {vld_r[2:0], vld_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m1_r  <= m1_nxt;
    m2_r  <= m2_nxt;
    m3_r  <= m3_nxt;
    out_r <= out_nxt;
  end

  assign vld_o  = vld_r[3];
  assign item_o = out_r;

endmodule

FILE: hdl/chi_out_buf.sv
module chi_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  output logic                 credit_ok,
  input  logic                 wr_vld,
  input  chi_pkg::chi_result_t wr_data,
  chi_out_if.source            out_chan
);
  import chi_pkg::*;

  localparam int CNT_W = BUF_AW + 1;

  chi_result_t mem [BUF_DEPTH];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill;
  logic             out_fire;
  logic             head_bypass;
  chi_result_t      rd_data_r;

  assign fill      = wr_ptr_r - rd_ptr_r;
  assign out_fire  = out_chan.valid & out_chan.ready;
  assign credit_ok = (cnt_r < CNT_W'(BUF_DEPTH));

  always_comb begin
    cnt_nxt    = cnt_r + CNT_W'(in_fire) - CNT_W'(out_fire);
    wr_ptr_nxt = wr_ptr_r + CNT_W'(wr_vld);
    rd_ptr_nxt = rd_ptr_r + CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // head register; a write to the next head slot goes straight through
  assign head_bypass = wr_vld & (wr_ptr_r == rd_ptr_nxt);

  always_ff @(posedge clk) begin
    if (wr_vld) begin
      mem[wr_ptr_r[BUF_AW-1:0]] <= wr_data;
    end
    if (head_bypass) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_ptr_nxt[BUF_AW-1:0]];
    end
  end

  assign out_chan.valid      = (fill != '0);
  assign out_chan.interp_pos = rd_data_r.pos;
  assign out_chan.saturated  = rd_data_r.sat;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_vld |-> (fill != CNT_W'(BUF_DEPTH)))
    else $error("result buffer written while full");

  a_fill_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= cnt_r)
    else $error("buffer holds more results than transactions in flight");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!credit_ok) |=> (cnt_r <= CNT_W'(BUF_DEPTH)))
    else $error("credit count above buffer depth");

endmodule

FILE: dv/tb_cubic_hermite_interpolator_core.sv
module tb_cubic_hermite_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import chi_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int N_RANDOM       = 1330;
  localparam int STEADY_FIRST   = 500;
  localparam int STEADY_LAST    = 800;
  localparam int IDLE_PCT       = 23;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [POS_W-1:0] P_MAX    = 40'sh7F_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] P_MIN    = 40'sh80_0000_0000;
  localparam logic signed [VEL_W-1:0] V_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [VEL_W-1:0] V_MIN    = 32'sh8000_0000;
  localparam logic [SPAN_W-1:0]       SPAN_MAX = 32'hFFFF_FFFF;
  localparam logic [T_W-1:0]          T_ONE    = 17'h1_0000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [T_W-1:0]          frac_t;
    logic [SPAN_W-1:0]       step_span;
    logic signed [POS_W-1:0] start_pos;
    logic signed [VEL_W-1:0] start_vel;
    logic signed [POS_W-1:0] end_pos;
    logic signed [VEL_W-1:0] end_vel;
  } segment_t;

  class hermite_ledger;
    chi_result_t pending_points[$];
    int          fault_cnt;

    function new();
      fault_cnt = 0;
    endfunction

    // magnitude product, round half away from zero, sign restored
    static function wide_t round_scale(wide_t a, logic [63:0] b, int sh);
      logic [127:0] m;
      logic [127:0] r;
      m = (a < 0) ? -a : a;
      r = (m * b + (128'd1 << (sh - 1))) >> sh;
      return (a < 0) ? -wide_t'(r) : wide_t'(r);
    endfunction

    static function chi_result_t eval_segment(segment_t s);
      wide_t       t, one, p0, p1, vd0, vd1, c2, c3, acc, lim_hi, lim_lo;
      chi_result_t res;
      one = wide_t'(1) << FRAC_BITS;
      t = s.frac_t;
      if (t > one) begin
        t = one;
      end
      p0  = s.start_pos;
      p1  = s.end_pos;
      vd0 = round_scale(wide_t'(s.start_vel), 64'(s.step_span), 16);
      vd1 = round_scale(wide_t'(s.end_vel), 64'(s.step_span), 16);
      c2  = 3 * (p1 - p0) - 2 * vd0 - vd1;
      c3  = 2 * (p0 - p1) + vd0 + vd1;
      acc = round_scale(c3, 64'(t), FRAC_BITS) + c2;
      acc = round_scale(acc, 64'(t), FRAC_BITS) + vd0;
      acc = round_scale(acc, 64'(t), FRAC_BITS) + p0;
      lim_hi = P_MAX;
      lim_lo = P_MIN;
      res.sat = 1'b0;
      if (acc > lim_hi) begin
        acc = lim_hi;
        res.sat = 1'b1;
      end else if (acc < lim_lo) begin
        acc = lim_lo;
        res.sat = 1'b1;
      end
      res.pos = acc[POS_W-1:0];
      return res;
    endfunction

    function void note_sample(segment_t s);
      pending_points.insert(pending_points.size(), eval_segment(s));
    endfunction

    function void check_point(logic signed [POS_W-1:0] pos, logic sat);
      chi_result_t want;
      if (pending_points.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS) begin
          $display("unexpected result transaction: interp_pos=%0d saturated=%0b", pos, sat);
        end
        return;
      end
      want = pending_points[0];
      pending_points.delete(0);
      if (want.pos !== pos || want.sat !== sat) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS) begin
          $display("mismatch: interp_pos exp %0d got %0d, saturated exp %0b got %0b",
                   want.pos, pos, want.sat, sat);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic steady;
  int   idle_cycles = 0;
  hermite_ledger ledger;

  chi_in_if  in_ch ();
  chi_out_if out_ch ();

  cubic_hermite_interpolator_core #(
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        ledger.note_sample({in_ch.frac_t, in_ch.step_span, in_ch.start_pos,
                            in_ch.start_vel, in_ch.end_pos, in_ch.end_vel});
      end
      if (out_ch.valid && out_ch.ready) begin
        ledger.check_point(out_ch.interp_pos, out_ch.saturated);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_segment(segment_t s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.frac_t    <= s.frac_t;
    in_ch.step_span <= s.step_span;
    in_ch.start_pos <= s.start_pos;
    in_ch.start_vel <= s.start_vel;
    in_ch.end_pos   <= s.end_pos;
    in_ch.end_vel   <= s.end_vel;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic push_fields(logic [T_W-1:0] t, logic [SPAN_W-1:0] dt,
                             logic signed [POS_W-1:0] p0, logic signed [VEL_W-1:0] v0,
                             logic signed [POS_W-1:0] p1, logic signed [VEL_W-1:0] v1);
    segment_t s;
    s = {t, dt, p0, v0, p1, v1};
    push_segment(s);
  endtask

  function automatic segment_t random_segment();
    segment_t    s;
    logic [63:0] r;
    int unsigned kind;
    int          d;
    kind = $urandom_range(99);
    if (kind < 30) begin
      s.frac_t    = T_W'($urandom);
      s.step_span = $urandom;
      r           = {$urandom, $urandom};
      s.start_pos = r[POS_W-1:0];
      s.start_vel = $urandom;
      r           = {$urandom, $urandom};
      s.end_pos   = r[POS_W-1:0];
      s.end_vel   = $urandom;
    end else begin
      s.frac_t    = ($urandom_range(19) == 0) ? T_W'($urandom_range(131071, 65537))
                                              : T_W'($urandom_range(65536));
      s.step_span = $urandom_range(8192);
      s.start_vel = int'($urandom_range(16777215)) - 8388608;
      s.end_vel   = int'($urandom_range(16777215)) - 8388608;
      if (kind < 45) begin
        // near the rails so overshoot clamps now and then
        if ($urandom_range(1) == 1) begin
          s.start_pos = P_MAX - $urandom_range(1048576);
          s.end_pos   = P_MAX - $urandom_range(1048576);
        end else begin
          s.start_pos = P_MIN + $urandom_range(1048576);
          s.end_pos   = P_MIN + $urandom_range(1048576);
        end
      end else begin
        r           = {$urandom, $urandom};
        s.start_pos = {{(POS_W-31){r[31]}}, r[30:0]};
        d           = int'($urandom_range(16777215)) - 8388608;
        s.end_pos   = s.start_pos + d;
      end
    end
    return s;
  endfunction

  initial begin
    ledger = new();
    steady <= 1'b0;
    rst_n <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.frac_t    <= '0;
    in_ch.step_span <= '0;
    in_ch.start_pos <= '0;
    in_ch.start_vel <= '0;
    in_ch.end_pos   <= '0;
    in_ch.end_vel   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_fields(17'h0, 32'h0, '0, '0, '0, '0);
    push_fields(T_ONE, 32'h100, 40'sd25600, 32'sh10000, 40'sd51200, -32'sh10000);
    push_fields(T_ONE + 17'd1, 32'h200, 40'sd1000, 32'sh20000, -40'sd3000, 32'sh30000);
    push_fields(17'h1_FFFF, 32'h300, -40'sd7777, -32'sh40000, 40'sd9999, 32'sh1000);
    push_fields(17'h0_8000, 32'h0, 40'sd1000, V_MAX, 40'sd5000, V_MIN);
    push_fields(17'h0_0001, SPAN_MAX, P_MAX, V_MAX, P_MAX, V_MAX);
    push_fields(17'h0_8000, SPAN_MAX, P_MAX, V_MAX, P_MAX, V_MIN);
    push_fields(17'h0_8000, SPAN_MAX, P_MIN, V_MIN, P_MIN, V_MAX);
    push_fields(17'h0, SPAN_MAX, P_MAX, V_MIN, P_MIN, V_MAX);
    push_fields(T_ONE, SPAN_MAX, P_MIN, V_MAX, P_MAX, V_MIN);
    push_fields(17'h0_8000, 32'h0, P_MAX, '0, P_MIN, '0);
    push_fields(17'h0_FFFF, 32'h1, '0, 32'sh8000, '0, -32'sh8000);
    push_fields(17'h0_4000, 32'h1, '0, 32'sh18000, '0, -32'sh18000);
    push_fields(17'h0_C000, 32'h8000_0000, -40'sd12345, 32'sh123456, 40'sd98765, -32'sh654321);
    push_fields(T_ONE, 32'h1, P_MAX, V_MAX, P_MAX, V_MAX);
    push_fields(17'h0_0001, SPAN_MAX, P_MIN, V_MIN, P_MIN, V_MIN);

    for (int i = 0; i < N_RANDOM; i++) begin
      steady <= (i >= STEADY_FIRST && i < STEADY_LAST);
      push_segment(random_segment());
    end
    steady <= 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (ledger.pending_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.fault_cnt == 0 && ledger.pending_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
